/* hw/rtl/rbdq_pkg.sv */
// Package for the ring buffer deque core: operation and status codes,
// field widths of the stream payloads and the per-cell control struct.
// No dependencies; used by every module of the core.
package rbdq_pkg;

    // Request kinds carried on the slave-side tuser.
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    // Result status carried on the master-side tuser.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    // Fixed widths of the stream fields.
    localparam int unsigned IN_VALUE_W   = 32;
    localparam int unsigned OUT_VALUE_W  = 32;
    localparam int unsigned OUT_LEVEL_W  = 7;
    localparam int unsigned OUT_TDATA_W  = 48;
    localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_VALUE_W - 2 * OUT_LEVEL_W;

    // Capacity after reset, and the floor below which it never halves.
    localparam int unsigned CAP_RESET    = 4;
    localparam int unsigned CAP_FLOOR    = 2;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_right;   // push front: every entry moves one cell back
        logic shift_left;    // pop front: every entry moves one cell forward
        logic load_tail;     // push back: the cell at the current count loads
    } t_cell_op;

    // Outcome of one request, from the controller to the top level.
    typedef struct packed {
        logic    pop_ok;
        t_status status;
    } t_ctrl_stat;

endpackage

/* hw/rtl/rbdq_cell.sv */
// One storage cell of the deque chain: holds one entry and trades it with
// its neighbors on front pushes and pops. Depends on rbdq_pkg.
// Cell position in the chain is fixed by the INDEX parameter.
module rbdq_cell #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned CNT_W      = 7,
    parameter int unsigned INDEX      = 0
) (
    input  logic                  i_clk,
    input  rbdq_pkg::t_cell_op    i_op,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [CNT_W-1:0]      i_rd_idx,
    input  logic [DATA_WIDTH-1:0] i_push_value,
    input  logic [DATA_WIDTH-1:0] i_from_front,
    input  logic [DATA_WIDTH-1:0] i_from_back,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;

    // Entry update: shift toward the back, toward the front, or load at the tail.
    always_ff @(posedge i_clk) begin
        if (i_op.shift_right) begin
            r_data <= i_from_front;
        end else if (i_op.shift_left) begin
            r_data <= i_from_back;
        end else if (i_op.load_tail && (i_count == MY_IDX)) begin
            r_data <= i_push_value;
        end
    end

    // The cell drives its entry onto the read bus only when addressed.
    assign o_data    = r_data;
    assign o_rd_data = (i_rd_idx == MY_IDX) ? r_data : '0;

endmodule

/* hw/rtl/rbdq_ctrl.sv */
// Controller of the deque core: occupancy count, logical capacity with its
// grow and shrink rule, request checking and the command for the cell chain.
// Depends on rbdq_pkg.
module rbdq_ctrl #(
    parameter int unsigned MAX_DEPTH = 64,
    parameter int unsigned CNT_W     = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  rbdq_pkg::t_op        i_op,
    output rbdq_pkg::t_cell_op   o_cell_op,
    output logic [CNT_W-1:0]     o_count,
    output logic [CNT_W-1:0]     o_rd_idx,
    output rbdq_pkg::t_ctrl_stat o_stat,
    output logic [CNT_W-1:0]     o_next_count,
    output logic [CNT_W-1:0]     o_next_cap
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MAX_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(MAX_DEPTH);
    localparam logic [CNT_W-1:0] FLOOR_C = CNT_W'(rbdq_pkg::CAP_FLOOR);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_cap;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     n_cap;
    logic                 w_ok;
    logic                 w_is_push;
    logic [CNT_W-1:0]     w_count_after;
    logic [CNT_W-1:0]     w_cap_after;
    logic [CNT_W:0]       w_grown;
    rbdq_pkg::t_status    w_status;

    // Request check against the current fill level.
    always_comb begin
        w_is_push = 1'b0;
        w_ok      = 1'b0;
        w_status  = rbdq_pkg::ST_OK;
        unique case (i_op) inside
            rbdq_pkg::OP_PUSH_FRONT, rbdq_pkg::OP_PUSH_BACK: begin
                w_is_push = 1'b1;
                w_ok      = (r_count != DEPTH_C);
                w_status  = w_ok ? rbdq_pkg::ST_OK : rbdq_pkg::ST_PUSH_FULL;
            end
            rbdq_pkg::OP_POP_FRONT, rbdq_pkg::OP_POP_BACK: begin
                w_ok      = (r_count != '0);
                w_status  = w_ok ? rbdq_pkg::ST_OK : rbdq_pkg::ST_POP_EMPTY;
            end
            default: begin
                w_ok      = 1'b0;
            end
        endcase
    end

    // Fill level after an accepted request, and the capacity rule applied to it.
    always_comb begin
        w_count_after = w_is_push ? (r_count + 1'b1) : (r_count - 1'b1);
        w_grown       = {r_cap, 1'b0};
        w_cap_after   = r_cap;
        if (w_count_after == r_cap) begin
            w_cap_after = (w_grown > DEPTH_X) ? DEPTH_C : w_grown[CNT_W-1:0];
        end else if ((r_cap > FLOOR_C) && (w_count_after <= (r_cap >> 2))) begin
            w_cap_after = r_cap >> 1;
        end
    end

    // Next state: rejected requests leave everything unchanged.
    always_comb begin
        n_count = r_count;
        n_cap   = r_cap;
        if (i_fire && w_ok) begin
            n_count = w_count_after;
            n_cap   = w_cap_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CNT_W'(rbdq_pkg::CAP_RESET);
        end else begin
            r_count <= n_count;
            r_cap   <= n_cap;
        end
    end

    // Chain command and read address.
    always_comb begin
        o_cell_op.shift_right = i_fire && w_ok && (i_op == rbdq_pkg::OP_PUSH_FRONT);
        o_cell_op.shift_left  = i_fire && w_ok && (i_op == rbdq_pkg::OP_POP_FRONT);
        o_cell_op.load_tail   = i_fire && w_ok && (i_op == rbdq_pkg::OP_PUSH_BACK);
        o_rd_idx = (i_op == rbdq_pkg::OP_POP_FRONT) ? '0 : (r_count - 1'b1);
    end

    assign o_count       = r_count;
    assign o_stat.pop_ok = w_ok && !w_is_push;
    assign o_stat.status = w_status;
    assign o_next_count  = n_count;
    assign o_next_cap    = n_cap;

    // The fill level never passes the physical depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("deque count above physical depth");

    // The logical capacity always covers the fill level.
    a_cap_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("logical capacity below fill level");

    // A rejected request changes neither count nor capacity.
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !w_ok) |=> ($stable(r_count) && $stable(r_cap)))
        else $error("rejected request changed deque state");

    // An accepted push raises the count by exactly one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_ok && w_is_push) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not advance the count");

endmodule

/* hw/rtl/ring_buffer_deque_core.sv */
// Ring buffer deque core: a chain of MAX_DEPTH entry cells with the front
// at cell 0, a controller for count and logical capacity, one result register.
// The result of a request is registered and valid in the cycle after its transfer.
// Throughput: one request per cycle while the result side takes every result;
// set by the cell shift and the one-entry result register.
// Reset (synchronous, active low) empties the deque, sets capacity to 4 and
// drops the result valid; cell contents are not cleared and are never read unwritten.
module ring_buffer_deque_core #(
    parameter int unsigned MAX_DEPTH  = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] popped_value, [38:32] occupancy,
                                        // [45:39] logical_capacity, [47:46] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int unsigned CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int unsigned LVL_W = rbdq_pkg::OUT_LEVEL_W;
    localparam int unsigned VAL_W = rbdq_pkg::OUT_VALUE_W;

    logic                     w_fire;
    rbdq_pkg::t_op            w_op;
    rbdq_pkg::t_cell_op       w_cell_op;
    rbdq_pkg::t_ctrl_stat     w_stat;
    logic [CNT_W-1:0]         w_count;
    logic [CNT_W-1:0]         w_rd_idx;
    logic [CNT_W-1:0]         w_next_count;
    logic [CNT_W-1:0]         w_next_cap;
    logic [DATA_WIDTH-1:0]    w_push_value;
    logic [DATA_WIDTH-1:0]    w_cell_data [MAX_DEPTH];
    logic [DATA_WIDTH-1:0]    w_cell_rd   [MAX_DEPTH];
    logic [DATA_WIDTH-1:0]    w_pick;
    logic signed [63:0]       w_pick_ext;
    logic [VAL_W-1:0]         w_popped;

    logic                     r_out_valid;
    logic [VAL_W-1:0]         r_popped;
    logic [LVL_W-1:0]         r_occupancy;
    logic [LVL_W-1:0]         r_capacity;
    rbdq_pkg::t_status        r_status;

    // A request transfers whenever the result register is free or being emptied.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_fire        = s_axis_tvalid && s_axis_tready;
    assign w_op          = rbdq_pkg::t_op'(s_axis_tuser);
    assign w_push_value  = DATA_WIDTH'({32'd0, s_axis_tdata});

    rbdq_ctrl #(
        .MAX_DEPTH (MAX_DEPTH),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_op         (w_op),
        .o_cell_op    (w_cell_op),
        .o_count      (w_count),
        .o_rd_idx     (w_rd_idx),
        .o_stat       (w_stat),
        .o_next_count (w_next_count),
        .o_next_cap   (w_next_cap)
    );

    // Cell chain: cell 0 is the front; each cell takes its neighbor's entry on a shift.
    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_front;
        logic [DATA_WIDTH-1:0] w_back;

        if (g == 0) begin : g_head
            assign w_front = w_push_value;
        end else begin : g_mid_front
            assign w_front = w_cell_data[g-1];
        end

        if (g == MAX_DEPTH - 1) begin : g_tail
            assign w_back = w_cell_data[g];
        end else begin : g_mid_back
            assign w_back = w_cell_data[g+1];
        end

        rbdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_cell_op),
            .i_count      (w_count),
            .i_rd_idx     (w_rd_idx),
            .i_push_value (w_push_value),
            .i_from_front (w_front),
            .i_from_back  (w_back),
            .o_data       (w_cell_data[g]),
            .o_rd_data    (w_cell_rd[g])
        );
    end

    // Read bus: only the addressed cell drives a nonzero value.
    always_comb begin
        w_pick = '0;
        for (int k = 0; k < MAX_DEPTH; k++) begin
            w_pick = w_pick | w_cell_rd[k];
        end
    end

    assign w_pick_ext = 64'(signed'(w_pick));
    assign w_popped   = w_stat.pop_ok ? w_pick_ext[VAL_W-1:0] : '0;

    // Result register: loads on every request transfer, clears when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_popped    <= w_popped;
            r_occupancy <= LVL_W'(w_next_count);
            r_capacity  <= LVL_W'(w_next_cap);
            r_status    <= w_stat.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{rbdq_pkg::OUT_PAD_W{1'b0}}, r_capacity, r_occupancy, r_popped};
    assign m_axis_tuser  = r_status;

    // Every request transfer produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("request transfer produced no result");

    // A pending result that is not taken stays in place.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_popped)))
        else $error("pending result lost before transfer");

    // A nonzero popped value only comes with a successful pop.
    a_popped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_stat.pop_ok) |=> (r_popped == '0))
        else $error("nonzero popped value without a pop");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for ring_buffer_deque_core: pushes and pops on both ends,
// each result compared with an in-bench prediction of the deque and its capacity.
// Depends on rbdq_pkg for operation and status codes and the result field widths.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned DEPTH      = 64;
    localparam int unsigned CLK_HALF   = 4;
    localparam int unsigned MAX_REPORT = 10;
    localparam int unsigned LVL_W      = rbdq_pkg::OUT_LEVEL_W;

    // Expected content of one result transfer.
    typedef struct packed {
        logic [rbdq_pkg::OUT_VALUE_W-1:0] popped;
        logic [rbdq_pkg::OUT_LEVEL_W-1:0] occupancy;
        logic [rbdq_pkg::OUT_LEVEL_W-1:0] capacity;
        rbdq_pkg::t_status                status;
    } t_dq_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] push_value
    logic [1:0]  s_axis_tuser  = rbdq_pkg::OP_PUSH_BACK;   // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;   // [31:0] popped_value, [38:32] occupancy,
                                 // [45:39] logical_capacity, [47:46] zero
    logic [1:0]  m_axis_tuser;   // [1:0] status

    // Predicted deque state.
    logic [31:0]                      ring_entries [DEPTH];
    logic [5:0]                       ring_head;
    logic [rbdq_pkg::OUT_LEVEL_W-1:0] ring_count;
    logic [rbdq_pkg::OUT_LEVEL_W-1:0] ring_capacity;

    t_dq_result pending_results [$];
    int         mismatch_count = 0;

    // Idle percentages of the current phase, and the long output hold request.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req_len   = 0;
    int unsigned hold_req_id    = 0;
    int unsigned hold_seen_id   = 0;
    int unsigned hold_left      = 0;

    ring_buffer_deque_core #(
        .MAX_DEPTH  (DEPTH),
        .DATA_WIDTH (32)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Grow when full to the logical capacity, shrink when a quarter full or less.
    function automatic void resize_capacity();
        int unsigned count;
        int unsigned cap;
        count = ring_count;
        cap   = ring_capacity;
        if (count == cap) begin
            cap = (cap * 2 > DEPTH) ? DEPTH : cap * 2;
        end else if (cap > rbdq_pkg::CAP_FLOOR && count <= cap / 4) begin
            cap = cap / 2;
        end
        ring_capacity = LVL_W'(cap);
    endfunction

    // Apply one request to the predicted deque and return the result it yields.
    function automatic t_dq_result predict_request(rbdq_pkg::t_op op, logic [31:0] value);
        t_dq_result r;
        r.popped = '0;
        r.status = rbdq_pkg::ST_OK;
        if (op == rbdq_pkg::OP_PUSH_FRONT || op == rbdq_pkg::OP_PUSH_BACK) begin
            if (ring_count >= DEPTH) begin
                r.status = rbdq_pkg::ST_PUSH_FULL;
            end else begin
                if (op == rbdq_pkg::OP_PUSH_FRONT) begin
                    ring_head = ring_head - 1'b1;
                    ring_entries[ring_head] = value;
                end else begin
                    ring_entries[6'(ring_head + ring_count)] = value;
                end
                ring_count = ring_count + 1'b1;
                resize_capacity();
            end
        end else begin
            if (ring_count == 0) begin
                r.status = rbdq_pkg::ST_POP_EMPTY;
            end else begin
                if (op == rbdq_pkg::OP_POP_FRONT) begin
                    r.popped  = ring_entries[ring_head];
                    ring_head = ring_head + 1'b1;
                end else begin
                    r.popped = ring_entries[6'(ring_head + ring_count - 1'b1)];
                end
                ring_count = ring_count - 1'b1;
                resize_capacity();
            end
        end
        r.occupancy = ring_count;
        r.capacity  = ring_capacity;
        return r;
    endfunction

    // Random push value, with the extremes of the range mixed in.
    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        case ($urandom_range(15))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'hFFFF_FFFF;
            3:       v = 32'h0000_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic rbdq_pkg::t_op rand_push();
        return $urandom_range(1) ? rbdq_pkg::OP_PUSH_BACK : rbdq_pkg::OP_PUSH_FRONT;
    endfunction

    function automatic rbdq_pkg::t_op rand_pop();
        return $urandom_range(1) ? rbdq_pkg::OP_POP_BACK : rbdq_pkg::OP_POP_FRONT;
    endfunction

    // Offer one request after a random gap and record its result once it transfers.
    task automatic send_request(input rbdq_pkg::t_op op, input logic [31:0] value);
        logic was_ready;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        do begin
            @(negedge i_clk);
            was_ready = s_axis_tready;
            @(posedge i_clk);
        end while (!was_ready);
        pending_results.push_back(predict_request(op, value));
    endtask

    // Stop offering and wait until every result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, or a long hold once one is requested.
    always @(posedge i_clk) begin
        if (hold_req_id != hold_seen_id) begin
            hold_seen_id = hold_req_id;
            hold_left    = hold_req_len;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(negedge i_clk) begin : result_check
        t_dq_result got;
        t_dq_result want;
        logic [rbdq_pkg::OUT_PAD_W-1:0] pad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.popped    = m_axis_tdata[rbdq_pkg::OUT_VALUE_W-1:0];
            got.occupancy = m_axis_tdata[rbdq_pkg::OUT_VALUE_W +: rbdq_pkg::OUT_LEVEL_W];
            got.capacity  = m_axis_tdata[rbdq_pkg::OUT_VALUE_W + rbdq_pkg::OUT_LEVEL_W
                                         +: rbdq_pkg::OUT_LEVEL_W];
            got.status    = rbdq_pkg::t_status'(m_axis_tuser);
            pad           = m_axis_tdata[rbdq_pkg::OUT_TDATA_W-1 -: rbdq_pkg::OUT_PAD_W];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORT)
                    $display("%0t: unexpected result: value %h occ %0d cap %0d status %0d",
                             $realtime, got.popped, got.occupancy, got.capacity, got.status);
            end else begin
                want = pending_results.pop_front();
                if (got !== want || pad !== '0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT)
                        $display({"%0t: mismatch: expected value %h occ %0d cap %0d ",
                                  "status %0d, got value %h occ %0d cap %0d status %0d ",
                                  "pad %b"},
                                 $realtime, want.popped, want.occupancy, want.capacity,
                                 want.status, got.popped, got.occupancy, got.capacity,
                                 got.status, pad);
                end
            end
        end
    end

    // Pops on an empty deque, extreme values at both ends, growth and shrink of capacity.
    task automatic test_edge_values_and_empty();
        send_request(rbdq_pkg::OP_POP_FRONT,  32'h1234_5678);
        send_request(rbdq_pkg::OP_POP_BACK,   32'hFFFF_FFFF);
        send_request(rbdq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF);
        send_request(rbdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_request(rbdq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF);
        send_request(rbdq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
        send_request(rbdq_pkg::OP_PUSH_BACK,  32'hAAAA_AAAA);
        send_request(rbdq_pkg::OP_PUSH_FRONT, 32'h5555_5555);
        send_request(rbdq_pkg::OP_POP_BACK,   32'h0000_0000);
        send_request(rbdq_pkg::OP_POP_FRONT,  32'h0000_0000);
        send_request(rbdq_pkg::OP_POP_FRONT,  32'hFFFF_FFFF);
        send_request(rbdq_pkg::OP_POP_BACK,   32'h0000_0000);
        send_request(rbdq_pkg::OP_POP_BACK,   32'h0000_0000);
        send_request(rbdq_pkg::OP_POP_FRONT,  32'h0000_0000);
        send_request(rbdq_pkg::OP_POP_BACK,   32'h0000_0000);
        send_request(rbdq_pkg::OP_POP_FRONT,  32'h0000_0000);
    endtask

    // Fill past the full depth, then drain past empty, each begun while the output is held off.
    task automatic test_fill_with_output_held();
        hold_req_len = 200;
        hold_req_id  = hold_req_id + 1;
        repeat (DEPTH + 6) send_request(rand_push(), rand_value());
        hold_req_len = 150;
        hold_req_id  = hold_req_id + 1;
        repeat (DEPTH + 6) send_request(rand_pop(), rand_value());
    endtask

    // Random traffic in segments that lean toward pushes, toward pops or neither, so the deque
    // swings between empty and full.
    task automatic test_mixed_traffic(input int unsigned num_items);
        int unsigned seg_left;
        int unsigned push_pct;
        seg_left = 0;
        push_pct = 50;
        repeat (num_items) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(60, 10);
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 50;
                    default: push_pct = 15;
                endcase
            end
            seg_left--;
            if ($urandom_range(99) < push_pct)
                send_request(rand_push(), rand_value());
            else
                send_request(rand_pop(), rand_value());
        end
    endtask

    initial begin
        ring_head     = '0;
        ring_count    = '0;
        ring_capacity = LVL_W'(rbdq_pkg::CAP_RESET);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_values_and_empty();
        test_fill_with_output_held();
        drain_results();

        // No idling, sender idle, receiver stalling, both.
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_mixed_traffic(120);
        drain_results();
        send_idle_pct = 48; recv_stall_pct = 0;
        test_mixed_traffic(120);
        drain_results();
        send_idle_pct = 0;  recv_stall_pct = 48;
        test_mixed_traffic(120);
        drain_results();
        send_idle_pct = 31; recv_stall_pct = 31;
        test_mixed_traffic(120);
        drain_results();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog.
    initial begin
        #4ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
